[src/modbus_rtu_sensor_link_core_macros.svh]
// assertion macros for the checker file
`ifndef MODBUS_RTU_SENSOR_LINK_CORE_MACROS_SVH
`define MODBUS_RTU_SENSOR_LINK_CORE_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define MRSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("port assertion failed");

// next-cycle implication, disabled while rst_n is low
`define MRSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("port assertion failed");

`endif

[src/mrsl_pkg.sv]
package mrsl_pkg;

    localparam int FRAME_BYTES_DEF   = 16;
    localparam int READOUT_BYTES_DEF = 8;
    localparam int TIMER_WIDTH_DEF   = 24;

    localparam int CFG_DW = 24;
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_DEV_ADDR = 1'b0;
    localparam logic [CFG_IW-1:0] REG_TIMEOUT  = 1'b1;

    localparam logic [7:0]  DEV_ADDR_RST = 8'd1;
    localparam logic [23:0] TIMEOUT_RST  = 24'd100000;

    localparam logic [7:0]  FN_WRITE = 8'h06;
    localparam logic [7:0]  FN_READ  = 8'h03;
    localparam logic [15:0] READ_QTY = 16'h0001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int IDLE_FRAME_LEN = 7;
    localparam int CMD_LEN        = 8;
    localparam int READ_HDR       = 3;
    localparam int CMD_BODY_LAST  = 5;

    typedef enum logic [1:0] {
        FUNC_RX    = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_CMD     = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        V_DISTANCE  = 3'd0,
        V_WRITE_ACK = 3'd1,
        V_READ_DATA = 3'd2,
        V_IGNORED   = 3'd3,
        V_CRC_ERR   = 3'd4,
        V_ECHO_BAD  = 3'd5,
        V_OVERLONG  = 3'd6
    } t_verdict;

    localparam logic [1:0] ST_UNINIT = 2'd0;
    localparam logic [1:0] ST_NORMAL = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_WRITE = 2'd1;
    localparam logic [1:0] PEND_READ  = 2'd2;

    typedef enum logic [1:0] {
        JG_EMIT = 2'd0,
        JG_CMP  = 2'd1,
        JG_COPY = 2'd2
    } t_judge;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRC,
        S_SEND,
        S_JUDGE,
        S_CMP_RD,
        S_CMP_CHK,
        S_CP_RD,
        S_CP_WR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic crc_step;
        logic send;
        logic judge;
        logic cmp_rd;
        logic cmp_chk;
        logic cp_rd;
        logic cp_wr;
        logic fin;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic   tick_hit;
        logic   req_ok;
        logic   crc_last;
        logic   send_last;
        t_judge jg;
        logic   cmp_bad;
        logic   cmp_done;
        logic   cp_done;
        logic   out_free;
    } t_dp_sts;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/mrsl_ctrl.sv]
module mrsl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_func,
    input  logic               i_last,
    input  mrsl_pkg::t_dp_sts  i_sts,
    output logic               o_ready,
    output mrsl_pkg::t_dp_cmd  o_cmd
);
    import mrsl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_func)
                        FUNC_RX: begin
                            if (i_last) n_state = S_JUDGE;
                        end
                        FUNC_TICK: begin
                            if (i_sts.tick_hit) n_state = S_EMIT;
                        end
                        default: begin
                            if (i_sts.req_ok) n_state = S_CRC;
                        end
                    endcase
                end
            end
            S_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (i_sts.crc_last) n_state = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.send = 1'b1;
                    if (i_sts.send_last) n_state = S_IDLE;
                end
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                case (i_sts.jg)
                    JG_CMP:  n_state = S_CMP_RD;
                    JG_COPY: n_state = S_CP_RD;
                    default: n_state = S_EMIT;
                endcase
            end
            S_CMP_RD: begin
                if (i_sts.cmp_done) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.cmp_rd = 1'b1;
                    n_state      = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                o_cmd.cmp_chk = 1'b1;
                n_state = i_sts.cmp_bad ? S_EMIT : S_CMP_RD;
            end
            S_CP_RD: begin
                if (i_sts.cp_done) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.cp_rd = 1'b1;
                    n_state     = S_CP_WR;
                end
            end
            S_CP_WR: begin
                o_cmd.cp_wr = 1'b1;
                n_state     = S_CP_RD;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[src/mrsl_dp.sv]
module mrsl_dp #(
    parameter int FRAME_BYTES   = mrsl_pkg::FRAME_BYTES_DEF,
    parameter int READOUT_BYTES = mrsl_pkg::READOUT_BYTES_DEF,
    parameter int TIMER_WIDTH   = mrsl_pkg::TIMER_WIDTH_DEF,
    parameter int OW            = 56
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mrsl_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [mrsl_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic [1:0]                  i_func,
    input  logic [7:0]                  i_rx_byte,
    input  logic [15:0]                 i_reg_addr,
    input  logic [15:0]                 i_reg_value,
    input  mrsl_pkg::t_dp_cmd           i_cmd,
    output mrsl_pkg::t_dp_sts           o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_out_kind,
    output logic                        o_out_last,
    output logic [OW-1:0]               o_out_data
);
    import mrsl_pkg::*;

    localparam int FAW  = $clog2(FRAME_BYTES);
    localparam int CW   = $clog2(FRAME_BYTES + 2);
    localparam int RBW  = $clog2(READOUT_BYTES + 1);
    localparam int RIW  = $clog2(READOUT_BYTES);
    localparam int IMAX = (READOUT_BYTES > CMD_LEN) ? READOUT_BYTES : CMD_LEN;
    localparam int IW   = $clog2(IMAX + 1);
    localparam int CMPW = (TIMER_WIDTH > CFG_DW) ? TIMER_WIDTH : CFG_DW;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic [7:0]             r_dev_addr;
    logic [CFG_DW-1:0]      r_timeout;
    logic [1:0]             r_pending;
    logic [7:0]             r_cmd [CMD_LEN];
    logic [15:0]            r_ccrc;
    logic [7:0]             r_mem [FRAME_BYTES];
    logic [7:0]             r_rd;
    logic [7:0]             r_fb [5];
    logic [CW-1:0]          r_count;
    logic [15:0]            r_crc;
    logic [TIMER_WIDTH-1:0] r_wait;
    logic [15:0]            r_dist;
    logic [1:0]             r_status;
    logic [7:0]             r_ro [READOUT_BYTES];
    logic [RBW-1:0]         r_rc;
    logic [IW-1:0]          r_idx;
    t_kind                  r_pkind;
    t_verdict               r_pverdict;
    logic                   r_ovalid;
    logic [1:0]             r_okind;
    logic                   r_olast;
    logic [OW-1:0]          r_odata;

    logic [TIMER_WIDTH-1:0] w_inc;
    logic                   hit;
    logic [IW:0]            idx3;
    logic [15:0]            n_ccrc;
    t_judge                 jg;
    t_verdict               jv;
    logic [RBW-1:0]         rc_cap;
    logic [7:0]             ro_hi, ro_lo;
    logic                   out_free;
    logic                   is_rx, is_tick, is_req;

    assign is_rx   = (i_func == FUNC_RX);
    assign is_tick = (i_func == FUNC_TICK);
    assign is_req  = !is_rx && !is_tick;

    assign w_inc  = (r_wait == TMAX) ? r_wait : r_wait + 1'b1;
    assign hit    = (CMPW'(w_inc) >= CMPW'(r_timeout)) || (w_inc == TMAX);
    assign idx3   = {1'b0, r_idx} + (IW + 1)'(READ_HDR);
    assign n_ccrc = crc_byte(r_ccrc, r_cmd[r_idx[2:0]]);
    assign rc_cap = (r_fb[2] > 8'(READOUT_BYTES)) ? RBW'(READOUT_BYTES) : RBW'(r_fb[2]);
    assign out_free = !r_ovalid || i_out_ready;
    assign ro_hi  = (r_rc > RBW'(0)) ? r_ro[0] : 8'h00;
    assign ro_lo  = (r_rc > RBW'(1)) ? r_ro[1] : 8'h00;

    always_comb begin
        jg = JG_EMIT;
        jv = V_IGNORED;
        if (r_count > CW'(FRAME_BYTES)) begin
            jv = V_OVERLONG;
        end else if (r_fb[0] != r_dev_addr) begin
            jv = V_IGNORED;
        end else begin
            case (r_pending)
                PEND_NONE: begin
                    if (r_count != CW'(IDLE_FRAME_LEN)) jv = V_IGNORED;
                    else if (r_crc != 16'h0000)         jv = V_CRC_ERR;
                    else                                jv = V_DISTANCE;
                end
                PEND_WRITE: begin
                    if (r_count == CW'(CMD_LEN)) begin
                        jg = JG_CMP;
                        jv = V_WRITE_ACK;
                    end
                end
                default: begin
                    if (r_count < CW'(READ_HDR) || r_crc != 16'h0000) begin
                        jv = V_CRC_ERR;
                    end else begin
                        jg = JG_COPY;
                        jv = V_READ_DATA;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_sts.tick_hit  = is_tick && (r_pending != PEND_NONE) && hit;
        o_sts.req_ok    = (r_pending == PEND_NONE);
        o_sts.crc_last  = (r_idx == IW'(CMD_BODY_LAST));
        o_sts.send_last = (r_idx == IW'(CMD_LEN - 1));
        o_sts.jg        = jg;
        o_sts.cmp_bad   = (r_rd != r_cmd[r_idx[2:0]]);
        o_sts.cmp_done  = (r_idx == IW'(CMD_LEN));
        o_sts.cp_done   = (r_idx == IW'(r_rc));
        o_sts.out_free  = out_free;
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_timeout  <= TIMEOUT_RST;
            r_pending  <= PEND_NONE;
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_wait     <= '0;
            r_dist     <= '0;
            r_status   <= ST_UNINIT;
            r_rc       <= '0;
            r_idx      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEV_ADDR: r_dev_addr <= i_cfg_data[7:0];
                    REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (is_rx) begin
                    if (r_count <= CW'(FRAME_BYTES)) r_count <= r_count + 1'b1;
                    r_crc <= crc_byte(r_crc, i_rx_byte);
                end else if (is_tick) begin
                    if (r_pending != PEND_NONE) begin
                        r_wait <= w_inc;
                        if (hit) begin
                            if (r_pending == PEND_READ) r_rc <= '0;
                            r_pending <= PEND_NONE;
                            r_status  <= ST_FAILED;
                        end
                    end
                end else if (r_pending == PEND_NONE) begin
                    r_pending <= (i_func == FUNC_WRITE) ? PEND_WRITE : PEND_READ;
                    r_wait    <= '0;
                    r_idx     <= '0;
                end
            end
            if (i_cmd.crc_step) begin
                r_idx <= o_sts.crc_last ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.send) r_idx <= r_idx + 1'b1;
            if (i_cmd.judge) begin
                r_idx <= '0;
                if (jv == V_DISTANCE) begin
                    r_dist   <= {r_fb[3], r_fb[4]};
                    r_status <= ST_NORMAL;
                end else if (jv == V_CRC_ERR) begin
                    if (r_pending == PEND_NONE) r_status <= ST_FAILED;
                    else                        r_rc     <= '0;
                end
                if (jg == JG_COPY) r_rc <= rc_cap;
            end
            if (i_cmd.cmp_chk) begin
                if (o_sts.cmp_bad) r_status <= ST_FAILED;
                else               r_idx    <= r_idx + 1'b1;
            end
            if (i_cmd.cp_wr) r_idx <= r_idx + 1'b1;
            if (i_cmd.fin) r_pending <= PEND_NONE;
            if (i_cmd.emit && r_pkind == KIND_FRAME) begin
                r_count <= '0;
                r_crc   <= CRC_INIT;
            end
            if (i_cmd.send || i_cmd.emit) r_ovalid <= 1'b1;
            else if (i_out_ready)         r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (is_rx) begin
                if (r_count < CW'(FRAME_BYTES)) r_mem[FAW'(r_count)] <= i_rx_byte;
                for (int k = 0; k < 5; k++) begin
                    if (r_count == CW'(k)) r_fb[k] <= i_rx_byte;
                end
            end else if (is_tick) begin
                r_pkind    <= KIND_TIMEOUT;
                r_pverdict <= V_DISTANCE;
            end else if (is_req && r_pending == PEND_NONE) begin
                r_cmd[0] <= r_dev_addr;
                r_cmd[1] <= (i_func == FUNC_WRITE) ? FN_WRITE : FN_READ;
                r_cmd[2] <= i_reg_addr[15:8];
                r_cmd[3] <= i_reg_addr[7:0];
                r_cmd[4] <= (i_func == FUNC_WRITE) ? i_reg_value[15:8] : READ_QTY[15:8];
                r_cmd[5] <= (i_func == FUNC_WRITE) ? i_reg_value[7:0]  : READ_QTY[7:0];
                r_ccrc   <= CRC_INIT;
            end
        end
        if (i_cmd.crc_step) begin
            r_ccrc <= n_ccrc;
            if (o_sts.crc_last) begin
                r_cmd[6] <= n_ccrc[7:0];
                r_cmd[7] <= n_ccrc[15:8];
            end
        end
        if (i_cmd.judge) begin
            r_pkind    <= KIND_FRAME;
            r_pverdict <= jv;
        end
        if (i_cmd.cmp_chk && o_sts.cmp_bad) r_pverdict <= V_ECHO_BAD;
        if (i_cmd.cmp_rd) r_rd <= r_mem[FAW'(r_idx)];
        if (i_cmd.cp_rd)  r_rd <= r_mem[FAW'(idx3)];
        if (i_cmd.cp_wr) begin
            r_ro[r_idx[RIW-1:0]] <= (32'(idx3) < 32'(r_count)) ? r_rd : 8'h00;
        end
        if (i_cmd.send) begin
            r_okind <= KIND_CMD;
            r_olast <= o_sts.send_last;
            r_odata <= OW'({ro_hi, ro_lo, r_rc, r_pending, r_status, r_dist,
                            V_DISTANCE, r_cmd[r_idx[2:0]]});
        end
        if (i_cmd.emit) begin
            r_okind <= r_pkind;
            r_olast <= 1'b0;
            r_odata <= OW'({ro_hi, ro_lo, r_rc, r_pending, r_status, r_dist,
                            r_pverdict, 8'h00});
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;
    assign o_out_data  = r_odata;

endmodule

[src/modbus_rtu_sensor_link_core.sv]
// channel   dir  tdata (low bit up)                                       tuser  tlast
// s_axis    in   rx_byte, register_address, register_value                func   rx_frame_end
// m_axis    out  tx_byte, verdict, distance, sensor_status, pending,      kind   last
//                read_length, read_value
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, no read-back
//
// a received byte or a tick is taken in the idle state, a tick that times out then emits;
// a request, after its accept, runs command crc (one byte per cycle) over six bytes, then
// outputs the eight command bytes, one word each; frame end: judge, then emit, with a read
// and a check per echo byte compared or a read and a write per readout byte copied between,
// paced by the single registered read port of the frame memory
// synchronous active-low reset; frame and readout memories need no clearing
// a stalled output holds its word and the controller waits on it
module modbus_rtu_sensor_link_core #(
    parameter int FRAME_BYTES   = mrsl_pkg::FRAME_BYTES_DEF,
    parameter int READOUT_BYTES = mrsl_pkg::READOUT_BYTES_DEF,
    parameter int TIMER_WIDTH   = mrsl_pkg::TIMER_WIDTH_DEF,
    localparam int OW = ((47 + $clog2(READOUT_BYTES + 1) + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mrsl_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [mrsl_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,  // rx_byte, register_address, register_value
    input  logic [1:0]                  s_axis_tuser,  // func
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OW-1:0]               m_axis_tdata,  // tx_byte, verdict, distance,
                                                       // sensor_status, pending,
                                                       // read_length, read_value
    output logic [1:0]                  m_axis_tuser,  // kind
    output logic                        m_axis_tlast
);
    import mrsl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mrsl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .i_sts   (sts),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    mrsl_dp #(
        .FRAME_BYTES   (FRAME_BYTES),
        .READOUT_BYTES (READOUT_BYTES),
        .TIMER_WIDTH   (TIMER_WIDTH),
        .OW            (OW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser),
        .i_rx_byte   (s_axis_tdata[7:0]),
        .i_reg_addr  (s_axis_tdata[23:8]),
        .i_reg_value (s_axis_tdata[39:24]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[src/mrsl_checker.sv]
`include "modbus_rtu_sensor_link_core_macros.svh"

module mrsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast,
    input logic [10:0] i_m_tdata_lo
);
    import mrsl_pkg::*;

    // a stalled word stays offered
    `MRSL_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)
    // only command bytes close a run
    `MRSL_ASSERT_IMP(a_last_cmd, i_clk, i_rst_n, i_m_tvalid && i_m_tlast, i_m_tuser == KIND_CMD)
    // verdict is zero outside frame verdict words
    `MRSL_ASSERT_IMP(a_verdict_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tuser != KIND_FRAME,
                     i_m_tdata_lo[10:8] == V_DISTANCE)
    // tx byte is zero outside command words
    `MRSL_ASSERT_IMP(a_tx_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tuser != KIND_CMD,
                     i_m_tdata_lo[7:0] == 8'h00)
    // reset empties the output register
    `MRSL_ASSERT_NXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !i_m_tvalid)

endmodule

bind modbus_rtu_sensor_link_core mrsl_checker u_mrsl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_m_tvalid   (m_axis_tvalid),
    .i_m_tready   (m_axis_tready),
    .i_m_tuser    (m_axis_tuser),
    .i_m_tlast    (m_axis_tlast),
    .i_m_tdata_lo (m_axis_tdata[10:0])
);
